// ----- hdl/frdr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frdr_pkg: shared types and constants for the frame rate drop/repeat block
// Widths of the rate registers, the phase and the count, the emit limit,
// the register map and the structs between the sequencer and the divider.
// ----------------------------------------------------------------------------
package frdr_pkg;

  // field and register widths
  localparam int unsigned RateW   = 18;
  localparam int unsigned FpsW    = 8;
  localparam int unsigned TagW    = 16;
  localparam int unsigned EmitW   = 6;
  localparam int unsigned IndexW  = 32;
  localparam int unsigned PhaseW  = 20;
  localparam int unsigned WideW   = PhaseW + 2;
  localparam int unsigned QuotW   = PhaseW - 1;
  localparam int unsigned CountW  = PhaseW;
  localparam int unsigned DivCntW = $clog2(QuotW);
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  // reset values of the rate registers
  localparam logic [RateW-1:0] RateReset = RateW'(30000);
  localparam logic [FpsW-1:0]  FpsReset  = FpsW'(30);
  localparam logic [RateW-1:0] MilliPerUnit = RateW'(1000);

  // clipping of the emit count
  localparam int unsigned MaxEmit      = 63;
  localparam int unsigned EmitFieldMax = (1 << EmitW) - 1;
  localparam int unsigned EmitLimit    = (MaxEmit < EmitFieldMax) ? MaxEmit : EmitFieldMax;
  localparam logic [EmitW-1:0] EmitLimitV = EmitW'(EmitLimit);

  // phase saturation bounds
  localparam logic signed [WideW-1:0] PhaseMax = WideW'((1 << (PhaseW - 1)) - 1);
  localparam logic signed [WideW-1:0] PhaseMin = -WideW'(1 << (PhaseW - 1));

  // register indexes (paddr[2])
  typedef enum logic {
    REG_INPUT_RATE = 1'b0,
    REG_OUTPUT_FPS = 1'b1
  } reg_idx_e;

  // conversion mode chosen per item
  typedef enum logic [1:0] {
    MODE_SAME   = 2'd0,
    MODE_DROP   = 2'd1,
    MODE_REPEAT = 2'd2
  } mode_e;

  // divider request and result
  typedef struct packed {
    logic             start;
    logic [QuotW-1:0] dividend;
    logic [RateW-1:0] divisor;
  } frdr_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
    logic [RateW-1:0] rem;
  } frdr_div_res_t;

endpackage

// ----- hdl/frdr_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frdr_div: iterative restoring divider
// One shared compare/subtract unit produces one quotient bit per cycle;
// done pulses for one cycle when quotient and remainder are final.
// ----------------------------------------------------------------------------
module frdr_div import frdr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  frdr_div_req_t req_i,
  output frdr_div_res_t res_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [QuotW-1:0]   dq_q, dq_d;
  logic [RateW-1:0]   rem_q, rem_d;
  logic [RateW-1:0]   divisor_q, divisor_d;

  logic [RateW:0]     trial;
  logic [RateW:0]     diff;
  logic               ge;

  // shared compare and subtract
  assign trial = {rem_q, dq_q[QuotW-1]};
  assign ge    = trial >= {1'b0, divisor_q};
  assign diff  = trial - {1'b0, divisor_q};

  // step sequencing
  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    dq_d      = dq_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    if (req_i.start) begin
      busy_d    = 1'b1;
      cnt_d     = DivCntW'(QuotW - 1);
      dq_d      = req_i.dividend;
      rem_d     = '0;
      divisor_d = req_i.divisor;
    end else if (busy_q) begin
      dq_d  = {dq_q[QuotW-2:0], ge};
      rem_d = ge ? diff[RateW-1:0] : trial[RateW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    dq_q      <= dq_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = dq_q;
  assign res_o.rem  = rem_q;

endmodule

// ----- hdl/frame_rate_drop_repeat.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rate_drop_repeat: drop/repeat frame rate converter
// For each input frame item, gives how many output copies to emit so that
// the output runs at a constant rate, plus the running output frame index.
// ----------------------------------------------------------------------------
// One item is taken at a time. With equal rates, in drop mode, or when the
// phase is negative, the item goes from S_IDLE straight to S_UPD, where the
// result is loaded into the output register. In repeat mode with a
// non-negative phase the copy count comes from an iterative divider that
// resolves one quotient bit per cycle while the block waits in S_DIV, and
// the result is loaded in S_UPD once the divider is done. In both cases
// loading waits while an earlier result is still stalled in the
// output register. The input is ready again the cycle after the result is
// loaded; the result may wait in the output register while the next item is
// taken. Rates are set through the APB port (input rate in thousandths of a
// frame/s at 0x0, output rate in frames/s at 0x4) and should be changed only
// while the block is idle.
module frame_rate_drop_repeat import frdr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  // input items
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [TagW-1:0]   frame_tag_i,
  // result items
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [TagW-1:0]   frame_tag_out_o,
  output logic [EmitW-1:0]  emit_count_o,
  output logic              count_saturated_o,
  output logic [IndexW-1:0] output_frame_index_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [RateW-1:0]  rate_q;
  logic [FpsW-1:0]   fps_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  logic [RateW-1:0]  t_in;
  logic [RateW-1:0]  t_out;
  mode_e             mode_cur;
  mode_e             mode_q, mode_d;
  logic [TagW-1:0]   tag_q, tag_d;

  logic signed [PhaseW-1:0] phase_q, phase_d;
  logic [IndexW-1:0]        out_cnt_q, out_cnt_d;

  logic              out_valid_q, out_valid_d;
  logic [TagW-1:0]   out_tag_q, out_tag_d;
  logic [EmitW-1:0]  out_emit_q, out_emit_d;
  logic              out_sat_q, out_sat_d;

  logic              in_acc;
  logic              out_free;
  logic              phase_pos;

  frdr_div_req_t     div_req;
  frdr_div_res_t     div_res;

  logic signed [WideW-1:0] phase_w;
  logic signed [WideW-1:0] t_out_w;
  logic signed [WideW-1:0] t_in_w;
  logic signed [WideW-1:0] rem_w;
  logic signed [WideW-1:0] base;
  logic signed [WideW-1:0] sum;
  logic [CountW-1:0]       count;

  // apb register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RateReset;
      fps_q  <= FpsReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_INPUT_RATE: rate_q <= pwdata[RateW-1:0];
        REG_OUTPUT_FPS: fps_q  <= pwdata[FpsW-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_INPUT_RATE: prdata = DataW'(rate_q);
      REG_OUTPUT_FPS: prdata = DataW'(fps_q);
      default:        prdata = '0;
    endcase
  end

  // periods and mode from the current rates
  assign t_in  = RateW'(fps_q) * MilliPerUnit;
  assign t_out = (rate_q == '0) ? RateW'(1) : rate_q;

  always_comb begin
    priority if (rate_q == t_in) mode_cur = MODE_SAME;
    else if (rate_q > t_in)      mode_cur = MODE_DROP;
    else                         mode_cur = MODE_REPEAT;
  end

  assign phase_pos = !phase_q[PhaseW-1];
  assign in_acc    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;

  // divider request
  assign div_req.start    = in_acc && (mode_cur == MODE_REPEAT) && phase_pos;
  assign div_req.dividend = phase_q[QuotW-1:0];
  assign div_req.divisor  = t_out;

  frdr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  // phase update and true copy count
  assign phase_w = WideW'(phase_q);
  assign t_out_w = WideW'({1'b0, t_out});
  assign t_in_w  = WideW'({1'b0, t_in});
  assign rem_w   = WideW'({1'b0, div_res.rem});

  always_comb begin
    base  = phase_w;
    count = '0;
    unique case (mode_q)
      MODE_SAME: begin
        count = CountW'(1);
      end
      MODE_DROP: begin
        if (phase_pos) begin
          base  = phase_w - t_out_w;
          count = CountW'(1);
        end
      end
      MODE_REPEAT: begin
        if (phase_pos) begin
          base  = rem_w - t_out_w;
          count = CountW'(div_res.quot) + CountW'(1);
        end
      end
      default: ;
    endcase
    sum = base + t_in_w;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    tag_d       = tag_q;
    phase_d     = phase_q;
    out_cnt_d   = out_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_tag_d   = out_tag_q;
    out_emit_d  = out_emit_q;
    out_sat_d   = out_sat_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          mode_d  = mode_cur;
          tag_d   = frame_tag_i;
          state_d = div_req.start ? S_DIV : S_UPD;
        end
      end
      S_DIV: begin
        if (div_res.done) state_d = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          if (mode_q != MODE_SAME) begin
            priority if (sum > PhaseMax) phase_d = PhaseMax[PhaseW-1:0];
            else if (sum < PhaseMin)     phase_d = PhaseMin[PhaseW-1:0];
            else                         phase_d = sum[PhaseW-1:0];
          end
          out_cnt_d   = out_cnt_q + IndexW'(count);
          out_valid_d = 1'b1;
          out_tag_d   = tag_q;
          out_sat_d   = count > CountW'(EmitLimit);
          out_emit_d  = out_sat_d ? EmitLimitV : count[EmitW-1:0];
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= '0;
      out_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_SAME;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_cnt_q   <= out_cnt_d;
      out_valid_q <= out_valid_d;
      mode_q      <= mode_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tag_q      <= tag_d;
    out_tag_q  <= out_tag_d;
    out_emit_q <= out_emit_d;
    out_sat_q  <= out_sat_d;
  end

  assign in_ready_o           = (state_q == S_IDLE);
  assign out_valid_o          = out_valid_q;
  assign frame_tag_out_o      = out_tag_q;
  assign emit_count_o         = out_emit_q;
  assign count_saturated_o    = out_sat_q;
  assign output_frame_index_o = out_cnt_q;

endmodule

// ----- hdl/frdr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frdr_checker: port-level checks for the frame rate drop/repeat block
// Watches the item handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module frdr_checker import frdr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [EmitW-1:0]  emit_count_o,
  input logic              count_saturated_o,
  input logic [IndexW-1:0] output_frame_index_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // a stalled result keeps its frame index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(output_frame_index_o))
    else $error("output frame index changed while stalled");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted while busy");

  // a clipped count shows the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && count_saturated_o |-> emit_count_o == EmitLimitV)
    else $error("saturated item without limit count");

  // a count above the limit never appears
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> emit_count_o <= EmitLimitV)
    else $error("emit count above limit");

endmodule

bind frame_rate_drop_repeat frdr_checker u_frdr_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_ready_o           (in_ready_o),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .emit_count_o         (emit_count_o),
  .count_saturated_o    (count_saturated_o),
  .output_frame_index_o (output_frame_index_o)
);

// ----- tb/frame_rate_drop_repeat_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rate_drop_repeat_test: self-checking bench for the drop/repeat block
// Drives frame items under bursty input and a stalling output, with the rate
// registers rewritten over the APB port between runs. A scoreboard tracks the
// phase and output count, predicts each copy count and index, and checks
// every result item in order.
// ----------------------------------------------------------------------------
module frame_rate_drop_repeat_test;
  import frdr_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int QuietLimit  = 4000;
  localparam int SettleCyc   = 30;
  localparam int RandomItems = 600;

  localparam longint PhaseTop    = (longint'(1) << (PhaseW - 1)) - 1;
  localparam longint PhaseBottom = -(longint'(1) << (PhaseW - 1));

  localparam int unsigned VideoRates [8] =
    '{23976, 24000, 25000, 29970, 30000, 50000, 59940, 60000};
  localparam int unsigned VideoFps [6] = '{24, 25, 30, 50, 60, 120};

  // one result item as seen on the output port
  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [EmitW-1:0]  emit;
    logic              sat;
    logic [IndexW-1:0] index;
  } frame_result_t;

  // phase tracker and store of expected frame results
  class frame_copy_board;
    logic [RateW-1:0]        rate_milli;
    logic [FpsW-1:0]         fps;
    logic signed [PhaseW-1:0] phase_q;
    logic [IndexW-1:0]       out_count_q;
    frame_result_t           pending_frames[$];
    int                      failures;

    function new();
      rate_milli  = RateReset;
      fps         = FpsReset;
      phase_q     = '0;
      out_count_q = '0;
      failures    = 0;
    endfunction

    function void set_register(reg_idx_e idx, logic [DataW-1:0] value);
      if (idx == REG_INPUT_RATE) begin
        rate_milli = value[RateW-1:0];
      end else begin
        fps = value[FpsW-1:0];
      end
    endfunction

    // true number of output copies for the arriving frame; advances the phase
    function longint predict_copies();
      longint t_in, t_out, phase, copies;
      mode_e  mode;
      t_in  = longint'(fps) * 1000;
      t_out = (rate_milli == 0) ? 1 : longint'(rate_milli);
      phase = longint'(phase_q);
      if (longint'(rate_milli) == t_in) mode = MODE_SAME;
      else if (longint'(rate_milli) > t_in) mode = MODE_DROP;
      else mode = MODE_REPEAT;
      case (mode)
        MODE_SAME: begin
          copies = 1;
        end
        MODE_DROP: begin
          copies = (phase >= 0) ? 1 : 0;
          phase  = phase - copies * t_out + t_in;
        end
        default: begin
          copies = (phase >= 0) ? phase / t_out + 1 : 0;
          phase  = phase - copies * t_out + t_in;
        end
      endcase
      // saturate to the signed phase range
      if (phase > PhaseTop) phase = PhaseTop;
      if (phase < PhaseBottom) phase = PhaseBottom;
      phase_q = PhaseW'(phase);
      return copies;
    endfunction

    function void note_frame(logic [TagW-1:0] tag);
      frame_result_t want;
      longint        copies;
      copies      = predict_copies();
      out_count_q = out_count_q + IndexW'(copies);
      want.tag    = tag;
      want.sat    = (copies > EmitLimit);
      want.emit   = want.sat ? EmitW'(EmitLimit) : EmitW'(copies);
      want.index  = out_count_q;
      pending_frames.push_back(want);
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (pending_frames.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result item with no frame outstanding: tag %h emit %0d sat %0d index %0d",
                   $realtime, got.tag, got.emit, got.sat, got.index);
        return;
      end
      want = pending_frames.pop_front();
      if (got.tag !== want.tag || got.emit !== want.emit || got.sat !== want.sat ||
          got.index !== want.index) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch (exp/got) tag %h/%h emit %0d/%0d sat %0d/%0d index %0d/%0d",
                   $realtime, want.tag, got.tag, want.emit, got.emit, want.sat, got.sat,
                   want.index, got.index);
      end
    endfunction

    function int pending();
      return pending_frames.size();
    endfunction
  endclass

  // block ports
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [TagW-1:0]   frame_tag_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [TagW-1:0]   frame_tag_out_o;
  logic [EmitW-1:0]  emit_count_o;
  logic              count_saturated_o;
  logic [IndexW-1:0] output_frame_index_o;

  frame_copy_board board;
  int  burst_left = 0;
  int  gap_style = 0;
  int  sent_frames = 0;
  int  quiet_cycles = 0;
  bit  hold_pending = 1'b0;
  int  hold_len = 0;

  frame_rate_drop_repeat dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .frame_tag_i          (frame_tag_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .frame_tag_out_o      (frame_tag_out_o),
    .emit_count_o         (emit_count_o),
    .count_saturated_o    (count_saturated_o),
    .output_frame_index_o (output_frame_index_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result(frame_result_t'({frame_tag_out_o, emit_count_o, count_saturated_o,
                                          output_frame_index_o}));
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: stall rate is redrawn after each random span, plus requested long holds
  initial begin
    int hold_left;
    int pct;
    int span;
    hold_left = 0;
    pct = 0;
    span = 0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = hold_len;
      end
      if (span == 0) begin
        span = $urandom_range(20, 200);
        case ($urandom_range(0, 4))
          0, 1: pct = 0;
          2: pct = 20;
          3: pct = 50;
          default: pct = 85;
        endcase
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= pct);
      end
    end
  end

  // gap after the current item: bursts of back-to-back items, each followed by a pause except in gap style 0
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(1, 16);
    case (gap_style)
      0: return 0;
      1: return $urandom_range(1, 3);
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  task automatic send_frame(logic [TagW-1:0] tag);
    int gap;
    gap = next_gap();
    in_valid_i  <= 1'b1;
    frame_tag_i <= tag;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_frame(tag);
    sent_frames++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // wait until every frame has its result, then let the block go quiet
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [DataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_register(idx, value);
  endtask

  // program both rates once idle; junk puts random bits above the fields
  task automatic set_rates(int unsigned rate, int unsigned fps, bit junk);
    logic [DataW-1:0] hi;
    hi = $urandom;
    drain_results();
    write_reg(REG_INPUT_RATE, junk ? {hi[DataW-1:RateW], RateW'(rate)} : DataW'(rate));
    hi = $urandom;
    write_reg(REG_OUTPUT_FPS, junk ? {hi[DataW-1:FpsW], FpsW'(fps)} : DataW'(fps));
  endtask

  task automatic pick_rates(output int unsigned rate, output int unsigned fps);
    case ($urandom_range(0, 6))
      0: begin
        rate = VideoRates[$urandom_range(0, 7)];
        fps  = VideoFps[$urandom_range(0, 5)];
      end
      1: begin
        fps  = $urandom_range(1, 240);
        rate = fps * 1000;
      end
      2: begin
        rate = $urandom_range(1, 240000);
        fps  = $urandom_range(1, 240);
      end
      3: begin
        // deep repeat, often clipped
        rate = $urandom_range(1, 3000);
        fps  = $urandom_range(120, 240);
      end
      4: begin
        rate = $urandom_range(0, 1) ? 240000 : 1;
        fps  = $urandom_range(0, 1) ? 240 : 1;
      end
      5: begin
        // full register range, zero included
        rate = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 262143);
        fps  = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 255);
      end
      default: begin
        fps  = $urandom_range(1, 60);
        rate = fps * 1000 + $urandom_range(1, 100000);
      end
    endcase
  endtask

  task automatic run_frames(int count, int hold_at);
    gap_style = $urandom_range(0, 2);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) begin
        // long output stall while items keep coming
        hold_len = $urandom_range(300, 500);
        hold_pending = 1'b1;
        burst_left = 40;
      end
      send_frame(TagW'($urandom));
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned rate;
    int unsigned fps;
    int          phase_no;
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // same rate after reset, tag extremes
    gap_style = 0;
    send_frame(16'h0000);
    send_frame(16'hFFFF);
    // fastest input against slowest output: heavy drop
    set_rates(240000, 1, 1'b0);
    send_frame(16'hAAAA);
    send_frame(16'h5555);
    send_frame(16'h0001);
    // slowest input against fastest output: repeat with clipping
    set_rates(1, 240, 1'b0);
    send_frame(16'h8000);
    send_frame(16'h7FFF);
    send_frame(16'h1234);
    // zero input rate counts as one unit of output period
    set_rates(0, 240, 1'b0);
    send_frame(16'hFEDC);
    send_frame(16'h0F0F);
    // zero output rate makes the input period zero
    set_rates(1000, 0, 1'b0);
    send_frame(16'hF0F0);
    send_frame(16'h3C3C);
    set_rates(0, 0, 1'b0);
    send_frame(16'hC3C3);
    // register maxima with stray upper bits
    set_rates(262143, 255, 1'b1);
    send_frame(16'h00FF);
    send_frame(16'hFF00);
    // typical repeat and drop, phase carried from before
    set_rates(24000, 60, 1'b0);
    for (int i = 0; i < 4; i++) send_frame(TagW'($urandom));
    set_rates(60000, 24, 1'b0);
    for (int i = 0; i < 4; i++) send_frame(TagW'($urandom));

    // random runs across rate settings
    sent_frames = 0;
    phase_no = 0;
    while (sent_frames < RandomItems) begin
      pick_rates(rate, fps);
      set_rates(rate, fps, $urandom_range(0, 4) == 0);
      run_frames($urandom_range(30, 90), (phase_no == 1) ? 5 : -1);
      phase_no++;
    end

    drain_results();
    if (board.failures == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
